// ===== hdl/lmss_pkg.sv =====
// lmss_pkg: shared types and constants of the LED matrix scan serializer.
// Used by lmss_front, lmss_back and led_matrix_scan_serializer_unit.
`timescale 1ns / 1ps

package lmss_pkg;

    localparam int IDX_W      = 6;
    localparam int PIX_W      = 8;
    localparam int ROW_W      = 3;
    localparam int BIT_W      = 4;
    localparam int FC_W       = 4;
    localparam int RPT_W      = 10;
    localparam int OUT_FRM_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_LAST = 2'd1;

    localparam logic [FC_W-1:0]  FRAME_COUNT_RST = 4'd2;
    localparam logic [RPT_W-1:0] REPEAT_LAST_RST = 10'd500;

    localparam logic [BIT_W-1:0] LAST_BIT = 4'd15;
    localparam logic [ROW_W-1:0] LAST_ROW = 3'd7;

    typedef struct packed {
        logic             tick;
        logic [IDX_W-1:0] index;
        logic [PIX_W-1:0] pixel;
    } t_op;

    typedef struct packed {
        logic [FC_W-1:0]  frame_count;
        logic [RPT_W-1:0] repeat_last;
    } t_cfg;

    typedef struct packed {
        logic                 serial_bit;
        logic                 latch_strobe;
        logic [ROW_W-1:0]     row_now;
        logic [OUT_FRM_W-1:0] frame_now;
    } t_result;

endpackage

// ===== hdl/led_matrix_scan_serializer_unit.sv =====
// Scan serializer for an 8x8 LED matrix behind a chain of two shift registers. Each tick item
// yields one serial bit: per row the active-low row select byte, then the row's frame byte,
// both LSB first, with the latch strobe on the sixteenth bit; write items load the frame store
// and yield nothing. One item is taken per clock while the input queue has room, and one result
// leaves per clock while the result queue is not empty; ticks wait while it has no room.
// A tick's result passes the input queue, frame store read register and result queue. The store
// reads as zero after reset with no clearing time. Depends on lmss_pkg, lmss_front and lmss_back.
`timescale 1ns / 1ps

module led_matrix_scan_serializer_unit
    import lmss_pkg::*;
#(
    parameter int MAX_FRAMES = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  i_kind,
    input  logic [IDX_W-1:0]      i_store_index,
    input  logic [PIX_W-1:0]      i_pixel_byte,
    output logic                  empty,
    input  logic                  pop,
    output logic                  o_serial_bit,
    output logic                  o_latch_strobe,
    output logic [ROW_W-1:0]      o_row_now,
    output logic [OUT_FRM_W-1:0]  o_frame_now,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    logic    op_valid;
    t_op     op;
    logic    op_pop;
    t_result result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_count <= FRAME_COUNT_RST;
            r_cfg.repeat_last <= REPEAT_LAST_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FRAME_COUNT: r_cfg.frame_count <= i_cfg_data[FC_W-1:0];
                CFG_REPEAT_LAST: r_cfg.repeat_last <= i_cfg_data[RPT_W-1:0];
                default: ;
            endcase
        end
    end

    lmss_front #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_kind        (i_kind),
        .i_store_index (i_store_index),
        .i_pixel_byte  (i_pixel_byte),
        .o_op_valid    (op_valid),
        .o_op          (op),
        .i_op_pop      (op_pop)
    );

    lmss_back #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_op_valid (op_valid),
        .i_op       (op),
        .o_op_pop   (op_pop),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_result   (result)
    );

    assign o_serial_bit   = result.serial_bit;
    assign o_latch_strobe = result.latch_strobe;
    assign o_row_now      = result.row_now;
    assign o_frame_now    = result.frame_now;

endmodule

// ===== hdl/lmss_front.sv =====
// lmss_front: input side; classifies items and queues them for the scan engine.
// Depends on lmss_pkg.
`timescale 1ns / 1ps

module lmss_front
    import lmss_pkg::*;
#(
    parameter int MAX_FRAMES = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic             i_kind,
    input  logic [IDX_W-1:0] i_store_index,
    input  logic [PIX_W-1:0] i_pixel_byte,
    output logic             o_op_valid,
    output t_op              o_op,
    input  logic             i_op_pop
);

    localparam int DEPTH = MAX_FRAMES * 8;
    localparam int QD    = 4;
    localparam int QP_W  = 2;
    localparam int QC_W  = 3;

    t_op               r_q [QD];
    logic [QP_W-1:0]   r_wr_ptr;
    logic [QP_W-1:0]   r_rd_ptr;
    logic [QC_W-1:0]   r_cnt;
    logic              in_range;
    logic              keep;
    logic              enq;
    logic              deq;
    t_op               op_in;

    assign in_range = 32'(i_store_index) < 32'(DEPTH);
    assign keep     = (i_kind == KIND_TICK) || in_range;
    assign o_full   = r_cnt == QC_W'(QD);
    assign enq      = i_push && !o_full && keep;
    assign deq      = i_op_pop && (r_cnt != '0);

    assign op_in.tick  = (i_kind == KIND_TICK);
    assign op_in.index = i_store_index;
    assign op_in.pixel = i_pixel_byte;

    assign o_op_valid = r_cnt != '0;
    assign o_op       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (enq) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (deq) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (enq && !deq) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!enq && deq) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wr_ptr] <= op_in;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QC_W'(QD))
        else $error("front queue count above depth");

    a_drop_no_enq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full && !keep && !deq) |=> (r_cnt == $past(r_cnt)))
        else $error("dropped write entered the queue");

endmodule

// ===== hdl/lmss_back.sv =====
// lmss_back: scan engine; frame store, row/bit/repeat/frame counters, result queue.
// Depends on lmss_pkg.
`timescale 1ns / 1ps

module lmss_back
    import lmss_pkg::*;
#(
    parameter int MAX_FRAMES = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_op_valid,
    input  t_op     i_op,
    output logic    o_op_pop,
    output logic    o_empty,
    input  logic    i_pop,
    output t_result o_result
);

    localparam int DEPTH = MAX_FRAMES * 8;
    localparam int AW    = $clog2(DEPTH);
    localparam int FRM_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CMP_W = ((FRM_W > FC_W) ? FRM_W : FC_W) + 1;
    localparam int OQ_D  = 4;
    localparam int OQ_PW = 2;
    localparam int OQ_CW = 3;

    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;

    logic [BIT_W-1:0] r_bit;
    logic [ROW_W-1:0] r_row;
    logic [RPT_W-1:0] r_rpt;
    logic [FRM_W-1:0] r_frame;

    logic                 r_b_valid;
    logic                 r_b_rowsel;
    logic                 r_b_rowbit;
    logic [2:0]           r_b_bitidx;
    logic                 r_b_latch;
    logic [ROW_W-1:0]     r_b_row;
    logic [OUT_FRM_W-1:0] r_b_frame;
    logic [PIX_W-1:0]     r_mem_q;
    logic                 r_vld_q;

    t_result           r_oq [OQ_D];
    logic [OQ_PW-1:0]  r_oq_wr;
    logic [OQ_PW-1:0]  r_oq_rd;
    logic [OQ_CW-1:0]  r_oq_cnt;

    logic             can_tick;
    logic             issue_tick;
    logic             issue_wr;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic [CMP_W-1:0] fc_ext;
    logic [CMP_W-1:0] eff_frames;
    logic [CMP_W-1:0] frame_inc;
    logic             oq_push;
    logic             oq_pop;
    t_result          b_result;

    assign can_tick   = (4'(r_oq_cnt) + 4'(r_b_valid)) < 4'(OQ_D);
    assign o_op_pop   = i_op_valid && (!i_op.tick || can_tick);
    assign issue_tick = o_op_pop && i_op.tick;
    assign issue_wr   = o_op_pop && !i_op.tick;

    assign wr_addr = AW'(i_op.index);
    assign rd_addr = AW'({r_frame, r_row});

    assign fc_ext    = CMP_W'(i_cfg.frame_count);
    assign frame_inc = CMP_W'(r_frame) + 1'b1;

    always_comb begin
        if (fc_ext == '0) begin
            eff_frames = CMP_W'(1);
        end else if (fc_ext > CMP_W'(MAX_FRAMES)) begin
            eff_frames = CMP_W'(MAX_FRAMES);
        end else begin
            eff_frames = fc_ext;
        end
    end

    // advance scan counters, one bit per tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit   <= '0;
            r_row   <= '0;
            r_rpt   <= '0;
            r_frame <= '0;
        end else if (issue_tick) begin
            if (r_bit >= LAST_BIT) begin
                r_bit <= '0;
                if (r_row >= LAST_ROW) begin
                    r_row <= '0;
                    if (r_rpt >= i_cfg.repeat_last) begin
                        r_rpt <= '0;
                        if (frame_inc >= eff_frames) begin
                            r_frame <= '0;
                        end else begin
                            r_frame <= FRM_W'(frame_inc);
                        end
                    end else begin
                        r_rpt <= r_rpt + 1'b1;
                    end
                end else begin
                    r_row <= r_row + 1'b1;
                end
            end else begin
                r_bit <= r_bit + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (issue_wr) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue_wr) begin
            r_mem[wr_addr] <= i_op.pixel;
        end
        if (issue_tick) begin
            r_mem_q <= r_mem[rd_addr];
            r_vld_q <= r_vld[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= issue_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue_tick) begin
            r_b_rowsel <= !r_bit[BIT_W-1];
            r_b_rowbit <= r_bit[2:0] != (LAST_ROW - r_row);
            r_b_bitidx <= r_bit[2:0];
            r_b_latch  <= r_bit == LAST_BIT;
            r_b_row    <= r_row;
            r_b_frame  <= OUT_FRM_W'(r_frame);
        end
    end

    assign b_result.serial_bit   = r_b_rowsel ? r_b_rowbit : (r_vld_q & r_mem_q[r_b_bitidx]);
    assign b_result.latch_strobe = r_b_latch;
    assign b_result.row_now      = r_b_row;
    assign b_result.frame_now    = r_b_frame;

    assign oq_push  = r_b_valid;
    assign o_empty  = r_oq_cnt == '0;
    assign oq_pop   = i_pop && !o_empty;
    assign o_result = r_oq[r_oq_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wr  <= '0;
            r_oq_rd  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (oq_push) begin
                r_oq_wr <= r_oq_wr + 1'b1;
            end
            if (oq_pop) begin
                r_oq_rd <= r_oq_rd + 1'b1;
            end
            if (oq_push && !oq_pop) begin
                r_oq_cnt <= r_oq_cnt + 1'b1;
            end else if (!oq_push && oq_pop) begin
                r_oq_cnt <= r_oq_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (oq_push) begin
            r_oq[r_oq_wr] <= b_result;
        end
    end

    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (4'(r_oq_cnt) + 4'(r_b_valid)) <= 4'(OQ_D))
        else $error("result queue overrun");

    a_frame_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_frame) < 32'(MAX_FRAMES))
        else $error("frame counter beyond store");

    a_latch_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue_tick && r_bit == LAST_BIT) |=> (r_bit == '0 && r_b_latch && !r_b_rowsel))
        else $error("latch strobe out of step with bit counter");

endmodule
